// File: rtl/fud_pkg.sv
package fud_pkg;

  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_PCT    = 8'h25;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CASE_MASK = 8'hDF;
  localparam logic [7:0] HEX_ALPHA = 8'h41;
  localparam logic [7:0] HEX_ZERO  = 8'h30;

  // escape phase codes
  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_PCT  = 2'd1;
  localparam logic [1:0] ESC_HELD = 2'd2;

  localparam int unsigned NSLOT = 3;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       has_byte;
    logic       in_name;
    logic       pair_end;
  } res_t;

  // up to three results of one item, in delivery order
  typedef struct packed {
    logic [NSLOT-1:0] vld;
    res_t [NSLOT-1:0] slot;
  } bundle_t;

  // loose hex digit: anything from 'A' up folded to upper case, anything below offset from '0'
  function automatic logic [7:0] hex_digit(input logic [7:0] c);
    logic [7:0] d;
    if (c >= HEX_ALPHA) begin
      d = (c & CASE_MASK) - HEX_ALPHA + 8'd10;
    end else begin
      d = c - HEX_ZERO;
    end
    return d;
  endfunction

endpackage

// File: rtl/fud_in_if.sv
interface fud_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       last;

  modport source(output valid, output in_byte, output last, input ready);
  modport sink(input valid, input in_byte, input last, output ready);
endinterface

// File: rtl/fud_out_if.sv
interface fud_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       has_byte;
  logic       in_name;
  logic       pair_end;

  modport source(output valid, output out_byte, output has_byte, output in_name,
                 output pair_end, input ready);
  modport sink(input valid, input out_byte, input has_byte, input in_name,
               input pair_end, output ready);
endinterface

// File: rtl/form_urlencoded_decoder_unit.sv
// channel  | dir | signals
// in_ch    | in  | valid, ready, in_byte[7:0], last
// out_ch   | out | valid, ready, out_byte[7:0], has_byte, in_name, pair_end
//
// One raw byte is taken per cycle while each byte yields at most one result and out_ch takes every result.
// A byte that yields two or three results (flushed escape plus pair marker)
// holds in_ch.ready low until all but the last of them have been taken.
// The first result of an accepted byte appears in the cycle after accept, from the result register.
// Synchronous active-low reset returns to the name part with no escape pending.
// A stall on out_ch backs up into in_ch once the result register is full.
module form_urlencoded_decoder_unit
  import fud_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  fud_in_if.sink    in_ch,
  fud_out_if.source out_ch
);

  bundle_t bundle;
  res_t    res;
  logic    can_load;
  logic    accept;

  assign in_ch.ready = can_load;
  assign accept      = in_ch.valid && can_load;

  fud_step u_step (
    .clk     (clk),
    .rst_n   (rst_n),
    .load    (accept),
    .in_byte (in_ch.in_byte),
    .last    (in_ch.last),
    .bundle  (bundle)
  );

  fud_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (accept),
    .bundle    (bundle),
    .can_load  (can_load),
    .res_valid (out_ch.valid),
    .res_ready (out_ch.ready),
    .res       (res)
  );

  assign out_ch.out_byte = res.out_byte;
  assign out_ch.has_byte = res.has_byte;
  assign out_ch.in_name  = res.in_name;
  assign out_ch.pair_end = res.pair_end;

  a_marker_on_close: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> (bundle.vld[2] == (in_ch.last || (in_ch.in_byte == CH_AMP))))
    else $error("pair marker does not match closing byte");

  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (bundle.vld != '0)) |=> out_ch.valid)
    else $error("accepted item lost its results");

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_ch.valid |-> in_ch.ready)
    else $error("input stalled with no result pending");

  a_marker_no_data: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.pair_end) |-> !out_ch.has_byte)
    else $error("pair marker carries data");

endmodule

// File: rtl/fud_step.sv
module fud_step
  import fud_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       load,
  input  logic [7:0] in_byte,
  input  logic       last,
  output bundle_t    bundle
);

  logic [1:0] phase_r, phase_nxt;
  logic [7:0] held_r, held_nxt;
  logic       value_r, value_nxt;

  logic       is_amp;
  logic [7:0] c;
  logic [7:0] hi_dig;
  logic [7:0] dec_val;
  logic       en_a, en_b, en_c;
  logic [7:0] b_val;
  logic       consume;
  logic       value_b;

  always_comb begin
    is_amp  = (in_byte == CH_AMP);
    c       = (in_byte == CH_PLUS) ? CH_SPACE : in_byte;
    hi_dig  = hex_digit(held_r);
    dec_val = {hi_dig[3:0], 4'h0} + hex_digit(c);

    en_a      = 1'b0;
    en_b      = 1'b0;
    en_c      = 1'b0;
    b_val     = c;
    phase_nxt = phase_r;
    held_nxt  = held_r;

    if (is_amp) begin
      // flush a truncated escape, then close
      en_a  = (phase_r != ESC_NONE);
      en_b  = (phase_r >= ESC_HELD);
      b_val = held_r;
      en_c  = 1'b1;
    end else begin
      en_c = last;
      case (phase_r)
        ESC_NONE: begin
          if (c == CH_PCT) begin
            en_a      = last;
            phase_nxt = ESC_PCT;
          end else begin
            en_b = 1'b1;
          end
        end
        ESC_PCT: begin
          en_a      = last;
          en_b      = last;
          held_nxt  = c;
          phase_nxt = ESC_HELD;
        end
        default: begin
          en_b      = 1'b1;
          b_val     = dec_val;
          held_nxt  = '0;
          phase_nxt = ESC_NONE;
        end
      endcase
    end

    // first '=' of the name part switches to the value part
    consume   = en_b && !value_r && (b_val == CH_EQ);
    value_b   = value_r | consume;
    value_nxt = value_b;

    if (en_c) begin
      phase_nxt = ESC_NONE;
      held_nxt  = '0;
      value_nxt = 1'b0;
    end

    bundle.vld[0]  = en_a;
    bundle.slot[0] = '{out_byte: CH_PCT, has_byte: 1'b1, in_name: !value_r, pair_end: 1'b0};
    bundle.vld[1]  = en_b && !consume;
    bundle.slot[1] = '{out_byte: b_val, has_byte: 1'b1, in_name: !value_r, pair_end: 1'b0};
    bundle.vld[2]  = en_c;
    bundle.slot[2] = '{out_byte: 8'h00, has_byte: 1'b0, in_name: !value_b, pair_end: 1'b1};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= ESC_NONE;
      held_r  <= '0;
      value_r <= 1'b0;
    end else if (load) begin
      phase_r <= phase_nxt;
      held_r  <= held_nxt;
      value_r <= value_nxt;
    end
  end

endmodule

// File: rtl/fud_queue.sv
module fud_queue
  import fud_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    load,
  input  bundle_t bundle,
  output logic    can_load,
  output logic    res_valid,
  input  logic    res_ready,
  output res_t    res
);

  logic [NSLOT-1:0] vld_r, vld_nxt;
  res_t [NSLOT-1:0] slot_r;
  logic             take;

  always_comb begin
    res_valid = |vld_r;
    take      = res_valid && res_ready;
    // empty, or the last pending result leaves this cycle
    can_load  = !res_valid || (res_ready && $onehot(vld_r));

    if (vld_r[0]) begin
      res = slot_r[0];
    end else if (vld_r[1]) begin
      res = slot_r[1];
    end else begin
      res = slot_r[2];
    end

    vld_nxt = vld_r;
    if (load) begin
      vld_nxt = bundle.vld;
    end else if (take) begin
      // drop the lowest pending slot
      vld_nxt = vld_r & (vld_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      slot_r <= bundle.slot;
    end
  end

endmodule
